// File: rtl/line_rasterizer_unit_assert.svh
// ----------------------------------------------------------------------------
// Line rasterizer assertion macros
// Implication checks on the block clock, masked while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_UNIT_ASSERT_SVH
`define LINE_RASTERIZER_UNIT_ASSERT_SVH

// Same-cycle implication
`define LR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define LR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lr_pkg.sv
// ----------------------------------------------------------------------------
// Line rasterizer package
// Sequencer states, register map and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package lr_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DRAW
    } lr_state_t;

    localparam int unsigned PADDR_W = 4;

    localparam logic [1:0] REG_SCREEN_COLUMNS = 2'd0;
    localparam logic [1:0] REG_SCREEN_LINES   = 2'd1;
    localparam logic [1:0] REG_BUFFER_READY   = 2'd2;

    localparam logic [6:0] SCREEN_COLUMNS_RESET = 7'd64;
    localparam logic [6:0] SCREEN_LINES_RESET   = 7'd24;
    localparam logic       BUFFER_READY_RESET   = 1'b0;

endpackage

`default_nettype wire

// File: rtl/lr_line_if.sv
// ----------------------------------------------------------------------------
// Line request channel
// Valid/ready channel carrying two endpoints and a character code.
// ----------------------------------------------------------------------------
`default_nettype none

interface lr_line_if;

    logic              valid;
    logic              ready;
    logic signed [7:0] start_col;
    logic signed [7:0] start_row;
    logic signed [7:0] end_col;
    logic signed [7:0] end_row;
    logic        [7:0] glyph;

    modport source (
        output valid,
        output start_col,
        output start_row,
        output end_col,
        output end_row,
        output glyph,
        input  ready
    );

    modport sink (
        input  valid,
        input  start_col,
        input  start_row,
        input  end_col,
        input  end_row,
        input  glyph,
        output ready
    );

endinterface

`default_nettype wire

// File: rtl/lr_cell_if.sv
// ----------------------------------------------------------------------------
// Cell write channel
// Valid/ready channel carrying one render buffer write per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface lr_cell_if;

    logic        valid;
    logic        ready;
    logic [5:0]  cell_col;
    logic [5:0]  cell_row;
    logic [11:0] write_address;
    logic [7:0]  glyph_out;
    logic        last_cell;

    modport source (
        output valid,
        output cell_col,
        output cell_row,
        output write_address,
        output glyph_out,
        output last_cell,
        input  ready
    );

    modport sink (
        input  valid,
        input  cell_col,
        input  cell_row,
        input  write_address,
        input  glyph_out,
        input  last_cell,
        output ready
    );

endinterface

`default_nettype wire

// File: rtl/line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// Line rasterizer unit
// Bresenham lines into a character buffer, one cell per cycle if not stalled.
// ----------------------------------------------------------------------------
// line_in carries a line request (two endpoints and a character); cell_out
// carries one buffer write per cell of the line, left endpoint first, with
// last_cell set on the final write. The APB port holds the screen size and
// the buffer-ready flag; write it only while no line is in flight.
// A request is taken while idle and set up in the next cycle; cells then
// leave one per cycle unless stalled, stepped by a single shared error adder.
// A request that is dropped (buffer not ready, or an endpoint off screen)
// yields no transaction. line_in.ready is high only when the sequencer is
// idle; the last cell may still wait in the output register while the next
// request is taken.
// If cell_out.ready is low with a cell waiting, the output register holds and
// the stepper pauses. Reset empties the output register, idles the sequencer
// and loads the register reset values (64 columns, 24 lines, not ready).
// ----------------------------------------------------------------------------
`default_nettype none

module line_rasterizer_unit
    import lr_pkg::*;
#(
    parameter int unsigned MAX_DIM = 64
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    lr_line_if.sink                  line_in,
    lr_cell_if.source                cell_out
);

    localparam logic [6:0] MAX_DIM_W = 7'(MAX_DIM);

    // configuration
    logic [6:0] cols_reg;
    logic [6:0] lines_reg;
    logic       buf_ready_reg;
    logic [1:0] reg_idx;
    logic       cfg_write;
    logic [6:0] eff_cols;
    logic [6:0] eff_rows;

    // sequencer
    lr_state_t state_reg;
    lr_state_t state_next;
    logic      in_take;
    logic      load_cell;
    logic      line_ok;
    logic      last_step;

    // captured request
    logic [7:0] c1_reg;
    logic [7:0] r1_reg;
    logic [7:0] c2_reg;
    logic [7:0] r2_reg;
    logic [7:0] glyph_reg;

    // setup arithmetic
    logic       first_left;
    logic [5:0] lc;
    logic [5:0] lr;
    logic [5:0] rc;
    logic [5:0] rr;
    logic [5:0] dc;
    logic [5:0] adr;
    logic       neg_s;
    logic       steep_s;
    logic [5:0] major_s;
    logic [5:0] minor_s;
    logic signed [8:0] err_init;

    // stepper
    logic [5:0] major_reg;
    logic [5:0] minor_reg;
    logic [5:0] step_reg;
    logic signed [8:0] err_reg;
    logic signed [8:0] err_next;
    logic [5:0] cur_col_reg;
    logic [5:0] cur_row_reg;
    logic       neg_reg;
    logic       steep_reg;
    logic       err_pos;
    logic       col_adv;
    logic       row_adv;
    logic [12:0] addr_prod;

    // output register
    logic        out_valid_reg;
    logic [5:0]  out_col_reg;
    logic [5:0]  out_row_reg;
    logic [11:0] out_addr_reg;
    logic [7:0]  out_glyph_reg;
    logic        out_last_reg;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg      <= SCREEN_COLUMNS_RESET;
            lines_reg     <= SCREEN_LINES_RESET;
            buf_ready_reg <= BUFFER_READY_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_SCREEN_COLUMNS: cols_reg      <= pwdata[6:0];
                REG_SCREEN_LINES:   lines_reg     <= pwdata[6:0];
                REG_BUFFER_READY:   buf_ready_reg <= pwdata[0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SCREEN_COLUMNS: prdata = {25'd0, cols_reg};
            REG_SCREEN_LINES:   prdata = {25'd0, lines_reg};
            REG_BUFFER_READY:   prdata = {31'd0, buf_ready_reg};
            default:            prdata = 32'd0;
        endcase
    end

    assign eff_cols = (cols_reg > MAX_DIM_W) ? MAX_DIM_W : cols_reg;
    assign eff_rows = (lines_reg > MAX_DIM_W) ? MAX_DIM_W : lines_reg;

    // ------------------------------------------------------------------
    // Request capture
    // ------------------------------------------------------------------
    assign in_take = line_in.valid && line_in.ready;

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            c1_reg    <= line_in.start_col;
            r1_reg    <= line_in.start_row;
            c2_reg    <= line_in.end_col;
            r2_reg    <= line_in.end_row;
            glyph_reg <= line_in.glyph;
        end
    end

    // ------------------------------------------------------------------
    // Setup: validate, order left to right, fold slope
    // ------------------------------------------------------------------
    assign line_ok = buf_ready_reg
                  && !c1_reg[7] && (c1_reg[6:0] < eff_cols)
                  && !c2_reg[7] && (c2_reg[6:0] < eff_cols)
                  && !r1_reg[7] && (r1_reg[6:0] < eff_rows)
                  && !r2_reg[7] && (r2_reg[6:0] < eff_rows);

    assign first_left = c1_reg[5:0] < c2_reg[5:0];
    assign lc         = first_left ? c1_reg[5:0] : c2_reg[5:0];
    assign lr         = first_left ? r1_reg[5:0] : r2_reg[5:0];
    assign rc         = first_left ? c2_reg[5:0] : c1_reg[5:0];
    assign rr         = first_left ? r2_reg[5:0] : r1_reg[5:0];
    assign dc         = rc - lc;
    assign neg_s      = rr < lr;
    assign adr        = neg_s ? (lr - rr) : (rr - lr);
    assign steep_s    = adr > dc;
    assign major_s    = steep_s ? adr : dc;
    assign minor_s    = steep_s ? dc : adr;
    assign err_init   = signed'({2'b00, minor_s, 1'b0}) - signed'({3'b000, major_s});

    // ------------------------------------------------------------------
    // Shared error stepper
    // ------------------------------------------------------------------
    assign err_pos   = !err_reg[8] && (err_reg != 9'sd0);
    assign err_next  = err_reg + signed'({2'b00, minor_reg, 1'b0})
                     - (err_pos ? signed'({2'b00, major_reg, 1'b0}) : 9'sd0);
    assign col_adv   = !steep_reg || err_pos;
    assign row_adv   = steep_reg || err_pos;
    assign last_step = step_reg == major_reg;
    assign addr_prod = 13'(cur_row_reg) * 13'(eff_cols) + 13'(cur_col_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SETUP)
        begin
            major_reg   <= major_s;
            minor_reg   <= minor_s;
            step_reg    <= 6'd0;
            err_reg     <= err_init;
            cur_col_reg <= lc;
            cur_row_reg <= lr;
            neg_reg     <= neg_s;
            steep_reg   <= steep_s;
        end
        else if (load_cell)
        begin
            step_reg <= step_reg + 6'd1;
            err_reg  <= err_next;
            if (col_adv)
            begin
                cur_col_reg <= cur_col_reg + 6'd1;
            end
            if (row_adv)
            begin
                cur_row_reg <= neg_reg ? (cur_row_reg - 6'd1) : (cur_row_reg + 6'd1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = line_ok ? ST_DRAW : ST_IDLE;
            end
            ST_DRAW:
            begin
                if (load_cell && last_step)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        line_in.ready = 1'b0;
        load_cell     = 1'b0;
        unique case (state_reg)
            ST_IDLE:  line_in.ready = 1'b1;
            ST_SETUP: ;
            ST_DRAW:  load_cell = !out_valid_reg || cell_out.ready;
            default:  ;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_cell)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (cell_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_cell)
        begin
            out_col_reg   <= cur_col_reg;
            out_row_reg   <= cur_row_reg;
            out_addr_reg  <= addr_prod[11:0];
            out_glyph_reg <= glyph_reg;
            out_last_reg  <= last_step;
        end
    end

    assign cell_out.valid         = out_valid_reg;
    assign cell_out.cell_col      = out_col_reg;
    assign cell_out.cell_row      = out_row_reg;
    assign cell_out.write_address = out_addr_reg;
    assign cell_out.glyph_out     = out_glyph_reg;
    assign cell_out.last_cell     = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "line_rasterizer_unit_assert.svh"

    `LR_ASSERT_SAME(a_step_in_range, state_reg == ST_DRAW, step_reg <= major_reg, "step past major length")
    `LR_ASSERT_NEXT(a_last_ends_line, load_cell && last_step, state_reg == ST_IDLE, "line continues after last cell")
    `LR_ASSERT_SAME(a_setup_after_take, state_reg == ST_SETUP, $past(in_take), "setup without a request")

endmodule

`default_nettype wire
